// ===== rtl/core/uctd_pkg.sv =====
package uctd_pkg;

   localparam int VOCAB_ENTRIES = 8192;
   localparam int IDX_W         = $clog2(VOCAB_ENTRIES);
   localparam int CNT_W         = $clog2(VOCAB_ENTRIES + 1);
   localparam int ID_W          = 13;
   localparam int LIMIT_W       = 14;

   localparam logic [CNT_W-1:0]   RESERVED_IDS  = CNT_W'(4);
   localparam logic [ID_W-1:0]    UNKNOWN_ID    = ID_W'(3);
   localparam logic [LIMIT_W-1:0] LIMIT_RESET   = LIMIT_W'(8000);
   localparam logic [CNT_W-1:0]   ENTRIES_COUNT = CNT_W'(VOCAB_ENTRIES);

   localparam logic [7:0] LEAD4 = 8'hF0;
   localparam logic [7:0] LEAD3 = 8'hE0;
   localparam logic [7:0] LEAD2 = 8'hC0;
   localparam logic [7:0] SPACE = 8'h20;
   localparam logic [23:0] FW_EXCL   = 24'hEFBC81;
   localparam logic [23:0] FW_RPAREN = 24'hEFBC89;
   localparam logic [23:0] FW_PERIOD = 24'hEFBC8E;

   typedef struct packed {
      logic        token;
      logic        last;
      logic [31:0] key;
      logic [2:0]  len;
   } char_info_type;

   function automatic logic [2:0] lead_length(input logic [7:0] b);
      logic [2:0] n;
      if (b >= LEAD4) n = 3'd4;
      else if (b >= LEAD3) n = 3'd3;
      else if (b >= LEAD2) n = 3'd2;
      else n = 3'd1;
      return n;
   endfunction

   function automatic logic is_punct(input logic [7:0] b);
      logic p;
      case (b) inside
         8'h21, 8'h22, 8'h27, 8'h28, 8'h29, 8'h2C, 8'h2E,
         8'h3A, 8'h3B, 8'h3F, 8'h5B, 8'h5D, 8'h7B, 8'h7D: p = 1'b1;
         default: p = 1'b0;
      endcase
      return p;
   endfunction

   function automatic logic is_dropped(input logic [31:0] code, input logic [2:0] len);
      logic d;
      d = 1'b0;
      if (len == 3'd1) begin
         d = (code[31:24] <= SPACE) || code[31] || is_punct(code[31:24]);
      end else if (len == 3'd3) begin
         d = (code[31:8] == FW_EXCL) || (code[31:8] == FW_RPAREN)
             || (code[31:8] == FW_PERIOD);
      end
      return d;
   endfunction

   function automatic logic [31:0] key_of(input logic [31:0] code);
      logic [31:0] k;
      logic        zero_seen;
      k = code;
      zero_seen = 1'b0;
      for (int i = 3; i >= 0; i--) begin
         if (code[8*i +: 8] == 8'h00) zero_seen = 1'b1;
         if (zero_seen) k[8*i +: 8] = 8'h00;
      end
      return k;
   endfunction

endpackage

// ===== rtl/core/uctd_req_if.sv =====
interface uctd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       end_of_text;

   modport source (output valid, output byte_value, output end_of_text, input ready);
   modport sink (input valid, input byte_value, input end_of_text, output ready);
endinterface

// ===== rtl/core/uctd_rsp_if.sv =====
interface uctd_rsp_if;
   logic                     valid;
   logic                     ready;
   logic                     token_valid;
   logic [uctd_pkg::ID_W-1:0] token_id;
   logic                     is_new;
   logic [31:0]              char_code;
   logic [2:0]               char_len;
   logic                     last_of_text;

   modport source (output valid, output token_valid, output token_id, output is_new,
                   output char_code, output char_len, output last_of_text, input ready);
   modport sink (input valid, input token_valid, input token_id, input is_new,
                 input char_code, input char_len, input last_of_text, output ready);
endinterface

// ===== rtl/core/uctd_collect.sv =====
module uctd_collect (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [7:0]              byte_value,
   input  logic                    end_of_text,
   output uctd_pkg::char_info_type info
);

   logic [31:0] partial_ff, partial_in;
   logic [2:0]  expected_ff, expected_in;
   logic [2:0]  collected_ff, collected_in;
   logic [31:0] code;
   logic [2:0]  len;
   logic        done;

   always_comb begin
      partial_in   = partial_ff;
      expected_in  = expected_ff;
      collected_in = collected_ff;
      if (expected_ff == 3'd0) begin
         partial_in   = {byte_value, 24'h000000};
         expected_in  = uctd_pkg::lead_length(byte_value);
         collected_in = 3'd1;
      end else begin
         case (collected_ff)
            3'd1: partial_in[23:16] = byte_value;
            3'd2: partial_in[15:8]  = byte_value;
            3'd3: partial_in[7:0]   = byte_value;
            default: partial_in = partial_ff;
         endcase
         collected_in = collected_ff + 3'd1;
      end
      done = collected_in >= expected_in;
      code = partial_in;
      len  = expected_in;
      if (done || end_of_text) begin
         partial_in   = 32'h0;
         expected_in  = 3'd0;
         collected_in = 3'd0;
      end
   end

   always_comb begin
      info.token = done && !uctd_pkg::is_dropped(code, len);
      info.last  = end_of_text;
      info.key   = uctd_pkg::key_of(code);
      info.len   = len;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff   <= 32'h0;
         expected_ff  <= 3'd0;
         collected_ff <= 3'd0;
      end else if (accept) begin
         partial_ff   <= partial_in;
         expected_ff  <= expected_in;
         collected_ff <= collected_in;
      end
   end

endmodule

// ===== rtl/core/utf8_char_tokenizer_dictionary.sv =====
// UTF-8 character tokenizer with a vocabulary of up to 8192 ids. Bytes arrive one per
// request; when a byte completes a kept character, the character key is searched in an
// on-chip table one entry per cycle (single read port, registered read data). An
// end-of-text byte that yields no token goes straight to delivery and other bytes give
// no response. Unseen characters get the next id while the count is below
// min(vocab_limit, 8192), otherwise id 3. Ids 0..3 are reserved. One request is in
// flight at a time; a finished response waits in an output register while the next
// request is taken. Write vocab_limit only while idle.
module utf8_char_tokenizer_dictionary (
   input  logic                          clock,
   input  logic                          reset,
   uctd_req_if.sink                      req_bus,
   uctd_rsp_if.source                    rsp_bus,
   input  logic                          csr_write_enable,
   input  logic [uctd_pkg::LIMIT_W-1:0]  csr_write_data
);

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_SEARCH  = 3'b010,
      ST_DELIVER = 3'b100
   } state_type;

   state_type                     state_ff, state_in;
   logic [uctd_pkg::LIMIT_W-1:0]  vlimit_ff;
   logic [uctd_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [uctd_pkg::CNT_W-1:0]    rd_addr_ff, rd_addr_in;
   logic [uctd_pkg::CNT_W-1:0]    cmp_addr_ff;
   logic                          cmp_valid_ff, cmp_valid_in;
   logic [31:0]                   mem [uctd_pkg::VOCAB_ENTRIES];
   logic [31:0]                   rd_data_ff;
   logic                          wr_en;
   logic [uctd_pkg::CNT_W-1:0]    limit;
   logic                          match;
   logic                          accept;
   uctd_pkg::char_info_type       info;

   logic                          res_token_ff, res_token_in;
   logic [uctd_pkg::ID_W-1:0]     res_id_ff, res_id_in;
   logic                          res_fresh_ff, res_fresh_in;
   logic [31:0]                   res_key_ff, res_key_in;
   logic [2:0]                    res_len_ff, res_len_in;
   logic                          res_last_ff, res_last_in;

   logic                          rsp_valid_ff;
   logic                          out_free;

   uctd_collect u_collect (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .byte_value  (req_bus.byte_value),
      .end_of_text (req_bus.end_of_text),
      .info        (info)
   );

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign match         = cmp_valid_ff && (rd_data_ff == res_key_ff);

   always_comb begin
      if (vlimit_ff > uctd_pkg::LIMIT_W'(uctd_pkg::VOCAB_ENTRIES)) begin
         limit = uctd_pkg::ENTRIES_COUNT;
      end else begin
         limit = uctd_pkg::CNT_W'(vlimit_ff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rd_addr_in   = rd_addr_ff;
      cmp_valid_in = 1'b0;
      wr_en        = 1'b0;
      res_token_in = res_token_ff;
      res_id_in    = res_id_ff;
      res_fresh_in = res_fresh_ff;
      res_key_in   = res_key_ff;
      res_len_in   = res_len_ff;
      res_last_in  = res_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_token_in = info.token;
               res_id_in    = '0;
               res_fresh_in = 1'b0;
               res_key_in   = info.token ? info.key : 32'h0;
               res_len_in   = info.token ? info.len : 3'd0;
               res_last_in  = info.last;
               rd_addr_in   = uctd_pkg::RESERVED_IDS;
               if (info.token) begin
                  state_in = ST_SEARCH;
               end else if (info.last) begin
                  state_in = ST_DELIVER;
               end
            end
         end
         ST_SEARCH: begin
            if (match) begin
               res_id_in = cmp_addr_ff[uctd_pkg::ID_W-1:0];
               state_in  = ST_DELIVER;
            end else if (rd_addr_ff < count_ff) begin
               cmp_valid_in = 1'b1;
               rd_addr_in   = rd_addr_ff + uctd_pkg::CNT_W'(1);
            end else begin
               if (count_ff < limit) begin
                  wr_en        = 1'b1;
                  res_id_in    = count_ff[uctd_pkg::ID_W-1:0];
                  res_fresh_in = 1'b1;
                  count_in     = count_ff + uctd_pkg::CNT_W'(1);
               end else begin
                  res_id_in = uctd_pkg::UNKNOWN_ID;
               end
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // vocabulary store
   always_ff @(posedge clock) begin
      if (wr_en) mem[count_ff[uctd_pkg::IDX_W-1:0]] <= res_key_ff;
      rd_data_ff <= mem[rd_addr_ff[uctd_pkg::IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= uctd_pkg::RESERVED_IDS;
         vlimit_ff    <= uctd_pkg::LIMIT_RESET;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         if (csr_write_enable) vlimit_ff <= csr_write_data;
         if (state_ff == ST_DELIVER && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff   <= rd_addr_in;
      cmp_addr_ff  <= rd_addr_ff;
      res_token_ff <= res_token_in;
      res_id_ff    <= res_id_in;
      res_fresh_ff <= res_fresh_in;
      res_key_ff   <= res_key_in;
      res_len_ff   <= res_len_in;
      res_last_ff  <= res_last_in;
      if (state_ff == ST_DELIVER && out_free) begin
         rsp_bus.token_valid  <= res_token_ff;
         rsp_bus.token_id     <= res_id_ff;
         rsp_bus.is_new       <= res_fresh_ff;
         rsp_bus.char_code    <= res_key_ff;
         rsp_bus.char_len     <= res_len_ff;
         rsp_bus.last_of_text <= res_last_ff;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= uctd_pkg::ENTRIES_COUNT && count_ff >= uctd_pkg::RESERVED_IDS)
      else $error("entry count out of range");

   a_insert_step: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> count_ff == $past(count_ff) + uctd_pkg::CNT_W'(1))
      else $error("insert did not advance entry count");

   a_new_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bus.is_new) |->
         (rsp_bus.token_valid && rsp_bus.token_id >= uctd_pkg::ID_W'(4)))
      else $error("new entry with reserved id");

   a_search_range: assert property (@(posedge clock) disable iff (reset)
      cmp_valid_ff |-> (cmp_addr_ff < count_ff && cmp_addr_ff >= uctd_pkg::RESERVED_IDS))
      else $error("compare outside filled entries");

endmodule

// ===== test/utf8_tokenizer_checker.sv =====
module utf8_tokenizer_checker (
   input  logic                         clock,
   input  logic                         reset,
   uctd_req_if                          req_mon,
   uctd_rsp_if                          rsp_mon,
   input  logic                         csr_write_enable,
   input  logic [uctd_pkg::LIMIT_W-1:0] csr_write_data,
   output int                           mismatch_count,
   output int                           tokens_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [8*14-1:0] ASCII_MARKS = ".,!?;:\"'()[]{}";
   localparam logic [7:0]      HIGH_BIT    = 8'h80;

   typedef struct packed {
      logic                      token_valid;
      logic [uctd_pkg::ID_W-1:0] token_id;
      logic                      is_new;
      logic [31:0]               char_code;
      logic [2:0]                char_len;
      logic                      last_of_text;
   } token_type;

   token_type                    expected_tokens[$];
   logic [31:0]                  vocab_keys[$];
   logic [31:0]                  char_bytes;
   logic [2:0]                   char_need;
   logic [2:0]                   char_have;
   logic [uctd_pkg::LIMIT_W-1:0] vocab_limit;
   int                           mismatch_total = 0;

   function automatic logic [2:0] lead_bytes(input logic [7:0] b);
      if (b >= uctd_pkg::LEAD4) return 3'd4;
      if (b >= uctd_pkg::LEAD3) return 3'd3;
      if (b >= uctd_pkg::LEAD2) return 3'd2;
      return 3'd1;
   endfunction

   function automatic logic is_mark(input logic [7:0] b);
      for (int i = 0; i < 14; i++) begin
         if (ASCII_MARKS[8*i +: 8] == b) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic is_skipped_char(input logic [31:0] code, input logic [2:0] len);
      logic [7:0] first;
      first = code[31:24];
      case (len)
         3'd1: return first <= uctd_pkg::SPACE || first >= HIGH_BIT || is_mark(first);
         3'd3: return code[31:8] inside {uctd_pkg::FW_EXCL, uctd_pkg::FW_RPAREN,
                                         uctd_pkg::FW_PERIOD};
         default: return 1'b0;
      endcase
   endfunction

   // everything from the first zero byte down is cleared
   function automatic logic [31:0] char_key(input logic [31:0] code);
      for (int k = 0; k < 4; k++) begin
         if (code[31 - 8*k -: 8] == 8'h00) return code & ~(32'hFFFF_FFFF >> (8 * k));
      end
      return code;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t mismatch: %s", $time, msg);
      mismatch_total++;
   endtask

   task automatic compare_field(input string field, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", field, got, want));
   endtask

   task automatic tokenize_byte(input logic [7:0] b, input logic ends_text);
      token_type   t;
      logic        done;
      logic [31:0] code;
      logic [31:0] key;
      logic [2:0]  len;
      int          limit;
      int          hit;
      done = 1'b0;
      code = '0;
      len = '0;
      if (char_need == 3'd0) begin
         char_bytes = {b, 24'h0};
         char_need = lead_bytes(b);
         char_have = 3'd1;
      end else begin
         if (char_have inside {[3'd1:3'd3]}) char_bytes |= 32'(b) << (8 * (3 - char_have));
         char_have++;
      end
      if (char_have >= char_need) begin
         done = 1'b1;
         code = char_bytes;
         len = char_need;
      end
      if (done || ends_text) begin
         char_bytes = '0;
         char_need = '0;
         char_have = '0;
      end
      t = '0;
      t.last_of_text = ends_text;
      if (done && !is_skipped_char(code, len)) begin
         key = char_key(code);
         limit = (vocab_limit > uctd_pkg::VOCAB_ENTRIES) ? uctd_pkg::VOCAB_ENTRIES
                                                         : int'(vocab_limit);
         hit = -1;
         foreach (vocab_keys[i]) begin
            if (hit < 0 && vocab_keys[i] == key) hit = i;
         end
         t.token_valid = 1'b1;
         t.char_code = key;
         t.char_len = len;
         if (hit >= 0) begin
            t.token_id = uctd_pkg::ID_W'(hit + int'(uctd_pkg::RESERVED_IDS));
         end else if (vocab_keys.size() + int'(uctd_pkg::RESERVED_IDS) < limit) begin
            t.token_id = uctd_pkg::ID_W'(vocab_keys.size() + int'(uctd_pkg::RESERVED_IDS));
            t.is_new = 1'b1;
            vocab_keys.push_back(key);
         end else begin
            t.token_id = uctd_pkg::UNKNOWN_ID;
         end
         expected_tokens.push_back(t);
      end else if (ends_text) begin
         expected_tokens.push_back(t);
      end
   endtask

   task automatic check_token(input token_type got);
      token_type want;
      if (expected_tokens.size() == 0) begin
         report_mismatch($sformatf("unexpected response, char_code %h", got.char_code));
         return;
      end
      want = expected_tokens.pop_front();
      compare_field("token_valid", 32'(got.token_valid), 32'(want.token_valid));
      compare_field("token_id", 32'(got.token_id), 32'(want.token_id));
      compare_field("is_new", 32'(got.is_new), 32'(want.is_new));
      compare_field("char_code", got.char_code, want.char_code);
      compare_field("char_len", 32'(got.char_len), 32'(want.char_len));
      compare_field("last_of_text", 32'(got.last_of_text), 32'(want.last_of_text));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_tokens.delete();
         vocab_keys.delete();
         char_bytes = '0;
         char_need = '0;
         char_have = '0;
         vocab_limit = uctd_pkg::LIMIT_RESET;
      end else begin
         // responses first, so one from an older request never meets a new expectation
         if (rsp_mon.valid && rsp_mon.ready) begin
            check_token('{rsp_mon.token_valid, rsp_mon.token_id, rsp_mon.is_new,
                          rsp_mon.char_code, rsp_mon.char_len, rsp_mon.last_of_text});
         end
         if (req_mon.valid && req_mon.ready) tokenize_byte(req_mon.byte_value, req_mon.end_of_text);
         if (csr_write_enable) vocab_limit = csr_write_data;
      end
      tokens_pending <= expected_tokens.size();
      mismatch_count <= mismatch_total;
   end

endmodule

// ===== test/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 200;

   // bit 8 marks end of text
   localparam logic [8:0] OPENING_TEXT [25] = '{
      9'h041, 9'h042, 9'h141, 9'h020, 9'h100, 9'h021, 9'h07E, 9'h0BF,
      9'h0EF, 9'h0BC, 9'h081, 9'h0EF, 9'h0BC, 9'h089, 9'h0EF, 9'h0BC, 9'h18E,
      9'h0C3, 9'h000, 9'h0FF, 9'h09F, 9'h000, 9'h041, 9'h0E4, 9'h1B8
   };

   typedef enum logic [1:0] {READY_ALWAYS, READY_COIN, READY_SPARSE} ready_mode_type;

   logic                         clock;
   logic                         reset;
   logic                         csr_write_enable;
   logic [uctd_pkg::LIMIT_W-1:0] csr_write_data;
   int                           mismatch_count;
   int                           tokens_pending;
   int                           burst_left;
   int                           bytes_sent;
   int                           ready_left;
   ready_mode_type               ready_mode;

   uctd_req_if req_bus ();
   uctd_rsp_if rsp_bus ();

   utf8_char_tokenizer_dictionary u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   utf8_tokenizer_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_bus),
      .rsp_mon          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .tokens_pending   (tokens_pending)
   );

   always #1 clock = ~clock;

   // response side stalls in modes of random length
   always @(posedge clock) begin
      if (ready_left == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 2));
         ready_left = $urandom_range(16, 80);
      end else begin
         ready_left--;
      end
      case (ready_mode)
         READY_ALWAYS: rsp_bus.ready <= 1'b1;
         READY_COIN: rsp_bus.ready <= 1'($urandom_range(0, 1));
         default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   task automatic send_byte(input logic [7:0] b, input logic ends_text);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 8);
      end
      burst_left--;
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.byte_value <= b;
      req_bus.end_of_text <= ends_text;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_random_char(input logic closes_text);
      logic [7:0] seq [4];
      int         len;
      int         pick;
      pick = $urandom_range(0, 19);
      len = 1;
      if (pick < 6) begin
         seq[0] = ($urandom_range(0, 1) == 0) ? 8'(8'h61 + $urandom_range(0, 3))
                                              : 8'($urandom_range(8'h00, 8'hBF));
      end else if (pick < 9) begin
         seq[0] = ($urandom_range(0, 1) == 0) ? 8'hC3 : 8'($urandom_range(8'hC0, 8'hDF));
         len = 2;
      end else if (pick < 13) begin
         seq[0] = ($urandom_range(0, 1) == 0) ? 8'hE4 : 8'($urandom_range(8'hE0, 8'hEF));
         len = 3;
      end else if (pick < 16) begin
         seq[0] = ($urandom_range(0, 1) == 0) ? 8'hF0 : 8'($urandom_range(8'hF0, 8'hFF));
         len = 4;
      end else begin
         seq[0] = 8'($urandom_range(0, 255));
      end
      for (int i = 1; i < len; i++) begin
         seq[i] = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'(8'h80 + $urandom_range(0, 3));
      end
      // fullwidth marks and near misses
      if (len == 3 && $urandom_range(0, 2) == 0) begin
         seq[0] = 8'hEF;
         seq[1] = 8'hBC;
         case ($urandom_range(0, 3))
            0: seq[2] = uctd_pkg::FW_EXCL[7:0];
            1: seq[2] = uctd_pkg::FW_RPAREN[7:0];
            2: seq[2] = uctd_pkg::FW_PERIOD[7:0];
            default: seq[2] = 8'($urandom_range(0, 255));
         endcase
      end
      if (len > 1 && $urandom_range(0, 9) == 0) len = $urandom_range(1, len - 1);
      for (int i = 0; i < len; i++) send_byte(seq[i], closes_text && i == len - 1);
   endtask

   task automatic send_random_texts(input int n_bytes);
      int start;
      int n_chars;
      start = bytes_sent;
      while (bytes_sent - start < n_bytes) begin
         n_chars = $urandom_range(1, 6);
         for (int c = 0; c < n_chars; c++) send_random_char(c == n_chars - 1);
      end
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (tokens_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_vocab_limit(input logic [uctd_pkg::LIMIT_W-1:0] value);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_bus.valid = 1'b0;
      req_bus.byte_value = '0;
      req_bus.end_of_text = 1'b0;
      rsp_bus.ready = 1'b0;
      burst_left = 0;
      bytes_sent = 0;
      ready_left = 0;
      ready_mode = READY_ALWAYS;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_vocab_limit(uctd_pkg::LIMIT_W'(5));
      foreach (OPENING_TEXT[i]) send_byte(OPENING_TEXT[i][7:0], OPENING_TEXT[i][8]);
      set_vocab_limit(uctd_pkg::LIMIT_W'(0));
      send_random_texts(10);
      set_vocab_limit(uctd_pkg::LIMIT_W'(24));
      send_random_texts(25);
      set_vocab_limit(uctd_pkg::LIMIT_W'(uctd_pkg::VOCAB_ENTRIES));
      send_random_texts(25);
      set_vocab_limit({uctd_pkg::LIMIT_W{1'b1}});
      send_random_texts(20);
      set_vocab_limit(uctd_pkg::LIMIT_RESET);
      send_random_texts(10);
      wait_idle();

      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
